### sv/kmer_containment_filter_core_macros.svh
// assertion macros for the k-mer containment filter checker
// expects clock and reset in the scope of use
`ifndef KMER_CONTAINMENT_FILTER_CORE_MACROS_SVH
`define KMER_CONTAINMENT_FILTER_CORE_MACROS_SVH

// same-cycle implication
`define KCF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define KCF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/kcf_pkg.sv
// shared types, constants and helpers of the k-mer containment filter
// no dependencies
package kcf_pkg;

   localparam int DEF_MAX_KMER      = 5;
   localparam int DEF_ALPHABET_SIZE = 20;
   localparam int DEF_COUNT_WIDTH   = 32;

   localparam int OPCODE_W  = 2;
   localparam int RESIDUE_W = 5;
   localparam int KLEN_W    = 3;
   localparam int OUT_W     = 32;
   localparam int ROW_BITS  = 64;

   typedef logic [OPCODE_W-1:0]  opcode_type;
   typedef logic [RESIDUE_W-1:0] residue_type;
   typedef logic [KLEN_W-1:0]    klen_type;
   typedef logic [OUT_W-1:0]     out_count_type;

   localparam opcode_type OP_CLEAR     = 2'd0;
   localparam opcode_type OP_REFERENCE = 2'd1;
   localparam opcode_type OP_QUERY     = 2'd2;
   localparam opcode_type OP_UNUSED    = 2'd3;

   localparam klen_type KLEN_RESET = 3'd4;
   localparam klen_type KLEN_MIN   = 3'd2;

   function automatic longint kcf_pow(input int base, input int expo);
      longint acc;
      acc = 1;
      for (int i = 0; i < expo; i++) begin
         acc = acc * base;
      end
      return acc;
   endfunction

endpackage

### sv/kcf_req_if.sv
// request channel of the k-mer containment filter: one residue word per handshake
// depends on kcf_pkg
interface kcf_req_if import kcf_pkg::*; ();
   logic        valid;
   logic        ready;
   opcode_type  opcode;
   residue_type residue;
   logic        residue_valid;
   logic        last;

   modport source (output valid, output opcode, output residue, output residue_valid,
                   output last, input ready);
   modport sink   (input valid, input opcode, input residue, input residue_valid,
                   input last, output ready);
endinterface

### sv/kcf_rsp_if.sv
// response channel of the k-mer containment filter: three counts per word
// depends on kcf_pkg
interface kcf_rsp_if import kcf_pkg::*; ();
   logic          valid;
   logic          ready;
   out_count_type reference_kmers;
   out_count_type query_kmers;
   out_count_type query_hits;

   modport source (output valid, output reference_kmers, output query_kmers,
                   output query_hits, input ready);
   modport sink   (input valid, input reference_kmers, input query_kmers,
                   input query_hits, output ready);
endinterface

### sv/kcf_ram.sv
// generic simple dual-port ram, one write port, one registered read port
// no dependencies
module kcf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
)(
   input  logic                                   clock,
   input  logic                                   write_enable,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] write_address,
   input  logic [WIDTH-1:0]                       write_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] read_address,
   output logic [WIDTH-1:0]                       read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data <= mem_ff[read_address];
   end

endmodule

### sv/kmer_containment_filter_core.sv
// k-mer containment filter top level: window, presence table pipeline, counters
// depends on kcf_pkg, kcf_req_if, kcf_rsp_if, kcf_ram
//
//   channel   direction  handshake            word
//   req_chan  in         valid/ready          opcode, residue, residue_valid, last
//   rsp_chan  out        valid/ready          reference_kmers, query_kmers, query_hits
//   csr_*     in         write enable only    kmer_length
//
// one word per cycle while ready is high, through window, table read and read-modify-write stages
// a query word with last waits until no other result is in flight and the
// response register is empty; its result passes the s1, s2 and rsp registers
// clear and reset sweep the table one 64-bit row a cycle over ceil(A^K/64)
// rows (50000 at defaults), ready low meanwhile
// reset is synchronous, active high
module kmer_containment_filter_core
   import kcf_pkg::*;
#(
   parameter int MAX_KMER      = DEF_MAX_KMER,
   parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE,
   parameter int COUNT_WIDTH   = DEF_COUNT_WIDTH
)(
   input  logic      clock,
   input  logic      reset,
   kcf_req_if.sink   req_chan,
   kcf_rsp_if.source rsp_chan,
   input  logic      csr_write_enable,
   input  klen_type  csr_write_data
);

   localparam longint TABLE_DEPTH = kcf_pow(ALPHABET_SIZE, MAX_KMER);
   localparam int     IDX_W       = $clog2(TABLE_DEPTH);
   localparam int     BIT_W       = $clog2(ROW_BITS);
   localparam longint ROWS        = (TABLE_DEPTH + ROW_BITS - 1) / ROW_BITS;
   localparam int     ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int     PAD_W       = ROW_W + BIT_W;
   localparam int     HIST_N      = MAX_KMER - 1;
   localparam int     HI_W        = (HIST_N > 1) ? $clog2(HIST_N) : 1;
   localparam int     PI_W        = $clog2(MAX_KMER);

   typedef logic [IDX_W-1:0]       idx_type;
   typedef logic [ROW_W-1:0]       row_type;
   typedef logic [ROW_BITS-1:0]    row_data_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef struct packed {
      opcode_type       op;
      logic             formed;
      logic             last;
      logic [PAD_W-1:0] idx;
   } stage_type;

   idx_type pow_tab [MAX_KMER];

   for (genvar g = 0; g < MAX_KMER; g++) begin : g_pow
      assign pow_tab[g] = IDX_W'(kcf_pow(ALPHABET_SIZE, g));
   end

   klen_type    kmer_length_ff, kmer_length_in;
   idx_type     idx_ff, idx_in;
   klen_type    run_ff, run_in;
   residue_type hist_ff [HIST_N];
   residue_type hist_in [HIST_N];
   idx_type     drop_ff, drop_in;

   logic      s1_valid_ff, s1_valid_in;
   stage_type s1_ff, s1_in;
   logic      s2_valid_ff;
   stage_type s2_ff;

   logic         fwd_valid_ff, fwd_valid_in;
   row_type      fwd_row_ff;
   row_data_type fwd_data_ff;

   logic    clr_busy_ff, clr_busy_in;
   row_type clr_row_ff, clr_row_in;

   count_type ref_cnt_ff, ref_cnt_in;
   count_type qry_cnt_ff, qry_cnt_in;
   count_type hit_cnt_ff, hit_cnt_in;

   logic          rsp_valid_ff, rsp_valid_in;
   out_count_type rsp_ref_ff, rsp_qry_ff, rsp_hit_ff;

   klen_type         k;
   logic             invalid, req_ready, req_fire;
   idx_type          base, kmer_idx;
   klen_type         run_inc;
   logic [HI_W-1:0]  hsel;
   logic [PI_W-1:0]  psel;
   logic             res_pipe, clr_pipe, res_s2;
   row_type          s2_row;
   logic [BIT_W-1:0] s2_bit;
   row_data_type     ram_rdata, merged, ram_wdata;
   row_type          ram_waddr;
   logic             ram_we, wr_ref, hit;
   count_type        qry_next, hit_next;

   // window arithmetic
   always_comb begin
      if (kmer_length_ff < KLEN_MIN) begin
         k = KLEN_MIN;
      end else if (kmer_length_ff > KLEN_W'(MAX_KMER)) begin
         k = KLEN_W'(MAX_KMER);
      end else begin
         k = kmer_length_ff;
      end
      invalid  = !req_chan.residue_valid || (int'(req_chan.residue) >= ALPHABET_SIZE);
      base     = (run_ff == k) ? idx_ff - drop_ff : idx_ff;
      kmer_idx = IDX_W'(base * IDX_W'(ALPHABET_SIZE)) + IDX_W'(req_chan.residue);
      run_inc  = (run_ff < k) ? run_ff + KLEN_W'(1) : run_ff;
      hsel     = HI_W'(k - KLEN_MIN);
      psel     = PI_W'(k - KLEN_W'(1));
   end

   always_comb begin
      res_pipe  = (s1_valid_ff && s1_ff.op == OP_QUERY && s1_ff.last) ||
                  (s2_valid_ff && s2_ff.op == OP_QUERY && s2_ff.last);
      clr_pipe  = (s1_valid_ff && s1_ff.op == OP_CLEAR) ||
                  (s2_valid_ff && s2_ff.op == OP_CLEAR);
      req_ready = !clr_busy_ff && !clr_pipe &&
                  (!(req_chan.opcode == OP_QUERY && req_chan.last) ||
                   (!rsp_valid_ff && !res_pipe));
      req_fire  = req_chan.valid && req_ready;
   end

   assign req_chan.ready = req_ready;

   // stage 0: window update on accept or on a kmer_length write
   always_comb begin
      kmer_length_in = kmer_length_ff;
      idx_in         = idx_ff;
      run_in         = run_ff;
      hist_in        = hist_ff;
      drop_in        = drop_ff;
      s1_valid_in    = req_fire && (req_chan.opcode != OP_UNUSED);
      s1_in.op       = req_chan.opcode;
      s1_in.last     = req_chan.last;
      s1_in.formed   = 1'b0;
      s1_in.idx      = PAD_W'(kmer_idx);
      if (csr_write_enable) begin
         kmer_length_in = csr_write_data;
         idx_in         = '0;
         run_in         = '0;
      end else if (req_fire) begin
         if (req_chan.opcode == OP_CLEAR) begin
            idx_in = '0;
            run_in = '0;
         end else if (req_chan.opcode != OP_UNUSED) begin
            if (invalid) begin
               idx_in = '0;
               run_in = '0;
            end else begin
               idx_in       = kmer_idx;
               run_in       = run_inc;
               s1_in.formed = (run_inc == k);
               drop_in      = IDX_W'(hist_ff[hsel] * pow_tab[psel]);
               hist_in[0]   = req_chan.residue;
               for (int i = 1; i < HIST_N; i++) begin
                  hist_in[i] = hist_ff[i-1];
               end
            end
            if (req_chan.last) begin
               idx_in = '0;
               run_in = '0;
            end
         end
      end
   end

   // stage 2: read-modify-write of the presence row, counters, result, clear sweep
   always_comb begin
      s2_row    = s2_ff.idx[PAD_W-1:BIT_W];
      s2_bit    = s2_ff.idx[BIT_W-1:0];
      merged    = (fwd_valid_ff && fwd_row_ff == s2_row) ? fwd_data_ff : ram_rdata;
      hit       = merged[s2_bit];
      wr_ref    = s2_valid_ff && s2_ff.op == OP_REFERENCE && s2_ff.formed;
      ram_we    = clr_busy_ff || wr_ref;
      ram_waddr = clr_busy_ff ? clr_row_ff : s2_row;
      ram_wdata = clr_busy_ff ? '0 : (merged | (ROW_BITS'(1) << s2_bit));
      fwd_valid_in = wr_ref && !clr_busy_ff;

      ref_cnt_in = ref_cnt_ff;
      qry_next   = qry_cnt_ff;
      hit_next   = hit_cnt_ff;
      if (s2_valid_ff && s2_ff.op == OP_CLEAR) begin
         ref_cnt_in = '0;
         qry_next   = '0;
         hit_next   = '0;
      end else if (s2_valid_ff && s2_ff.formed) begin
         if (s2_ff.op == OP_REFERENCE) begin
            ref_cnt_in = (&ref_cnt_ff) ? ref_cnt_ff : ref_cnt_ff + COUNT_WIDTH'(1);
         end else begin
            qry_next = (&qry_cnt_ff) ? qry_cnt_ff : qry_cnt_ff + COUNT_WIDTH'(1);
            if (hit) begin
               hit_next = (&hit_cnt_ff) ? hit_cnt_ff : hit_cnt_ff + COUNT_WIDTH'(1);
            end
         end
      end
      res_s2     = s2_valid_ff && s2_ff.op == OP_QUERY && s2_ff.last;
      qry_cnt_in = res_s2 ? '0 : qry_next;
      hit_cnt_in = res_s2 ? '0 : hit_next;

      rsp_valid_in = res_s2 || (rsp_valid_ff && !rsp_chan.ready);

      clr_busy_in = clr_busy_ff;
      clr_row_in  = clr_row_ff;
      if (s2_valid_ff && s2_ff.op == OP_CLEAR) begin
         clr_busy_in = 1'b1;
         clr_row_in  = '0;
      end else if (clr_busy_ff) begin
         if (clr_row_ff == ROW_W'(ROWS - 1)) begin
            clr_busy_in = 1'b0;
         end else begin
            clr_row_in = clr_row_ff + ROW_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kmer_length_ff <= KLEN_RESET;
         idx_ff         <= '0;
         run_ff         <= '0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         fwd_valid_ff   <= 1'b0;
         clr_busy_ff    <= 1'b1;
         clr_row_ff     <= '0;
         ref_cnt_ff     <= '0;
         qry_cnt_ff     <= '0;
         hit_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         kmer_length_ff <= kmer_length_in;
         idx_ff         <= idx_in;
         run_ff         <= run_in;
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s1_valid_ff;
         fwd_valid_ff   <= fwd_valid_in;
         clr_busy_ff    <= clr_busy_in;
         clr_row_ff     <= clr_row_in;
         ref_cnt_ff     <= ref_cnt_in;
         qry_cnt_ff     <= qry_cnt_in;
         hit_cnt_ff     <= hit_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hist_ff     <= hist_in;
      drop_ff     <= drop_in;
      s1_ff       <= s1_in;
      s2_ff       <= s1_ff;
      fwd_row_ff  <= s2_row;
      fwd_data_ff <= ram_wdata;
      if (res_s2) begin
         rsp_ref_ff <= OUT_W'(ref_cnt_in);
         rsp_qry_ff <= OUT_W'(qry_next);
         rsp_hit_ff <= OUT_W'(hit_next);
      end
   end

   kcf_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (int'(ROWS))
   ) u_table (
      .clock         (clock),
      .write_enable  (ram_we),
      .write_address (ram_waddr),
      .write_data    (ram_wdata),
      .read_address  (s1_ff.idx[PAD_W-1:BIT_W]),
      .read_data     (ram_rdata)
   );

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.reference_kmers = rsp_ref_ff;
   assign rsp_chan.query_kmers     = rsp_qry_ff;
   assign rsp_chan.query_hits      = rsp_hit_ff;

endmodule

### sv/kcf_checker.sv
// port-level checks of the k-mer containment filter, bound to the top level
// depends on kcf_pkg and kmer_containment_filter_core_macros.svh
`include "kmer_containment_filter_core_macros.svh"

module kcf_checker
   import kcf_pkg::*;
(
   input logic          clock,
   input logic          reset,
   input logic          req_valid,
   input logic          req_ready,
   input opcode_type    req_opcode,
   input logic          req_last,
   input logic          rsp_valid,
   input logic          rsp_ready,
   input out_count_type rsp_reference_kmers,
   input out_count_type rsp_query_kmers,
   input out_count_type rsp_query_hits
);

   logic               req_fire;
   logic               query_end;
   logic               clear_fire;
   logic               rsp_stall;
   logic [3*OUT_W-1:0] rsp_word;

   assign req_fire   = req_valid && req_ready;
   assign query_end  = req_fire && req_opcode == OP_QUERY && req_last;
   assign clear_fire = req_fire && req_opcode == OP_CLEAR;
   assign rsp_stall  = rsp_valid && !rsp_ready;
   assign rsp_word   = {rsp_reference_kmers, rsp_query_kmers, rsp_query_hits};

   `KCF_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_word), "stalled word changed")
   `KCF_ASSERT_NOW(a_rsp_source, $rose(rsp_valid), $past(query_end, 3), "orphan response word")
   `KCF_ASSERT_NOW(a_one_result, query_end, !rsp_valid, "query end accepted while a response waits")
   `KCF_ASSERT_NEXT(a_clear_block, clear_fire, !req_ready, "word accepted right behind a clear")

endmodule

bind kmer_containment_filter_core kcf_checker u_kcf_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_chan.valid),
   .req_ready           (req_chan.ready),
   .req_opcode          (req_chan.opcode),
   .req_last            (req_chan.last),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_reference_kmers (rsp_chan.reference_kmers),
   .rsp_query_kmers     (rsp_chan.query_kmers),
   .rsp_query_hits      (rsp_chan.query_hits)
);

### dv/tb_kmer_containment_filter_core.sv
// self-checking testbench of kmer_containment_filter_core: a directed table of expected
// counts, then random residue sequences under several k-mer lengths, checked by a predictor
// depends on kcf_pkg, kcf_req_if, kcf_rsp_if and the core
module tb_kmer_containment_filter_core;
   import kcf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ALPHA        = DEF_ALPHABET_SIZE;
   localparam int MAX_K        = DEF_MAX_KMER;
   localparam int DRAIN_CYCLES = 10;
   localparam int PHASE_ITEMS  = 96;
   localparam int N_DIRECTED   = 27;
   localparam int N_PHASES     = 10;

   typedef struct packed {
      opcode_type  opcode;
      residue_type residue;
      logic        residue_valid;
      logic        last;
   } residue_word_type;

   typedef struct packed {
      out_count_type reference_kmers;
      out_count_type query_kmers;
      out_count_type query_hits;
   } count_set_type;

   typedef struct packed {
      opcode_type    opcode;
      residue_type   residue;
      logic          residue_valid;
      logic          last;
      logic          typed;
      out_count_type ref_k;
      out_count_type qry_k;
      out_count_type hits;
   } stim_row_type;

   // table starts empty with kmer_length 4 after reset
   localparam stim_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      '{OP_QUERY,     5'd0,  1'b1, 1'b1, 1'b1, 32'd0, 32'd0, 32'd0},
      '{OP_UNUSED,    5'd31, 1'b1, 1'b1, 1'b0, 32'd0, 32'd0, 32'd0},
      '{OP_REFERENCE, 5'd0,  1'b1, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
      '{OP_REFERENCE, 5'd1,  1'b1, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
      '{OP_REFERENCE, 5'd2,  1'b1, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
      '{OP_REFERENCE, 5'd3,  1'b1, 1'b1, 1'b0, 32'd0, 32'd0, 32'd0},
      '{OP_REFERENCE, 5'd19, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
      '{OP_REFERENCE, 5'd19, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
      '{OP_REFERENCE, 5'd19, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
      '{OP_REFERENCE, 5'd19, 1'b1, 1'b1, 1'b0, 32'd0, 32'd0, 32'd0},
      '{OP_QUERY,     5'd0,  1'b1, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
      '{OP_QUERY,     5'd1,  1'b1, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
      '{OP_QUERY,     5'd2,  1'b1, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
      '{OP_QUERY,     5'd3,  1'b1, 1'b1, 1'b1, 32'd2, 32'd1, 32'd1},
      '{OP_QUERY,     5'd31, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
      '{OP_QUERY,     5'd19, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
      '{OP_QUERY,     5'd19, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
      '{OP_QUERY,     5'd19, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
      '{OP_QUERY,     5'd19, 1'b1, 1'b1, 1'b1, 32'd2, 32'd1, 32'd1},
      '{OP_QUERY,     5'd19, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
      '{OP_QUERY,     5'd0,  1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
      '{OP_QUERY,     5'd19, 1'b1, 1'b1, 1'b1, 32'd2, 32'd0, 32'd0},
      '{OP_CLEAR,     5'd31, 1'b1, 1'b1, 1'b0, 32'd0, 32'd0, 32'd0},
      '{OP_QUERY,     5'd0,  1'b1, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
      '{OP_QUERY,     5'd1,  1'b1, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
      '{OP_QUERY,     5'd2,  1'b1, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
      '{OP_QUERY,     5'd3,  1'b1, 1'b1, 1'b1, 32'd0, 32'd1, 32'd0}
   };

   localparam klen_type PHASE_KLEN [N_PHASES] = '{
      KLEN_MIN, 3'd5, 3'd3, 3'd0, 3'd7, 3'd1, 3'd6, KLEN_RESET, 3'd5, KLEN_MIN
   };

   logic     clock = 1'b0;
   logic     reset;
   logic     csr_write_enable;
   klen_type csr_write_data;

   kcf_req_if req_chan ();
   kcf_rsp_if rsp_chan ();

   kmer_containment_filter_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state
   bit            kmer_present [int unsigned];
   int unsigned   window_index;
   int unsigned   run_length;
   out_count_type reference_total;
   out_count_type query_total;
   out_count_type hit_total;
   klen_type      kmer_length_shadow;

   count_set_type pending_counts [$];
   count_set_type expected_now;
   int unsigned   mismatch_count;
   int unsigned   burst_left;
   int unsigned   clears_left;
   int unsigned   stall_step;
   logic [31:0]   stall_map;
   logic [4:0]    stall_pos;

   function automatic int unsigned active_length();
      if (kmer_length_shadow < KLEN_MIN) return KLEN_MIN;
      if (kmer_length_shadow > MAX_K) return MAX_K;
      return kmer_length_shadow;
   endfunction

   function automatic out_count_type bump(input out_count_type c);
      return (c == '1) ? c : c + 1'b1;
   endfunction

   function automatic bit predict_counts(input residue_word_type w, output count_set_type res);
      int unsigned k;
      int unsigned span;
      bit          formed;
      k      = active_length();
      span   = 1;
      formed = 1'b0;
      res    = '0;
      if (w.opcode == OP_CLEAR) begin
         kmer_present.delete();
         window_index    = 0;
         run_length      = 0;
         reference_total = '0;
         query_total     = '0;
         hit_total       = '0;
         return 1'b0;
      end
      if (w.opcode == OP_UNUSED) return 1'b0;
      if (!w.residue_valid || w.residue >= ALPHA) begin
         window_index = 0;
         run_length   = 0;
      end else begin
         for (int i = 1; i < k; i++) span = span * ALPHA;
         window_index = (window_index % span) * ALPHA + w.residue;
         if (run_length < k) run_length++;
         formed = (run_length >= k);
      end
      if (formed) begin
         if (w.opcode == OP_REFERENCE) begin
            kmer_present[window_index] = 1'b1;
            reference_total = bump(reference_total);
         end else begin
            query_total = bump(query_total);
            if (kmer_present.exists(window_index)) hit_total = bump(hit_total);
         end
      end
      if (!w.last) return 1'b0;
      window_index = 0;
      run_length   = 0;
      if (w.opcode != OP_QUERY) return 1'b0;
      res.reference_kmers = reference_total;
      res.query_kmers     = query_total;
      res.query_hits      = hit_total;
      query_total = '0;
      hit_total   = '0;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // called at a falling edge, returns at the falling edge after the handshake
   task automatic send_residue(input residue_word_type w, input bit typed,
                               input count_set_type typed_counts);
      count_set_type predicted;
      int unsigned   gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      end
      burst_left--;
      req_chan.valid         <= 1'b1;
      req_chan.opcode        <= w.opcode;
      req_chan.residue       <= w.residue;
      req_chan.residue_valid <= w.residue_valid;
      req_chan.last          <= w.last;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      if (predict_counts(w, predicted)) pending_counts.push_back(typed ? typed_counts : predicted);
      @(negedge clock);
   endtask

   task automatic write_kmer_length(input klen_type v);
      req_chan.valid <= 1'b0;
      while (pending_counts.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(negedge clock);
      csr_write_enable   <= 1'b0;
      kmer_length_shadow = v;
      window_index       = 0;
      run_length         = 0;
      burst_left         = 0;
   endtask

   task automatic send_sequence(input opcode_type op, input bit with_last,
                                output int unsigned n_sent);
      residue_word_type w;
      int unsigned      len;
      int unsigned      r;
      bit               narrow;
      len    = ($urandom_range(99) < 85) ? $urandom_range(1, 10) : $urandom_range(11, 40);
      narrow = $urandom_range(1);
      for (int unsigned i = 0; i < len; i++) begin
         r = $urandom_range(99);
         w.opcode        = op;
         w.residue_valid = 1'b1;
         if (r < 4) begin
            w.residue_valid = 1'b0;
            w.residue       = $urandom_range(31);
         end else if (r < 7) begin
            w.residue = $urandom_range(ALPHA, 31);
         end else begin
            w.residue = narrow ? $urandom_range(3) : $urandom_range(ALPHA - 1);
         end
         // mixed kinds inside one window
         if ($urandom_range(99) < 3) w.opcode = (op == OP_QUERY) ? OP_REFERENCE : OP_QUERY;
         w.last = with_last && (i == len - 1);
         send_residue(w, 1'b0, '0);
      end
      n_sent = len;
   endtask

   task automatic run_phase(input int unsigned target);
      residue_word_type w;
      int unsigned      sent;
      int unsigned      n;
      int unsigned      r;
      sent = 0;
      while (sent < target) begin
         r = $urandom_range(99);
         if (r < 2 && clears_left != 0) begin
            clears_left--;
            w = {OP_CLEAR, 5'($urandom_range(31)), 1'($urandom_range(1)), 1'($urandom_range(1))};
            send_residue(w, 1'b0, '0);
            sent++;
         end else if (r < 6) begin
            w = {OP_UNUSED, 5'($urandom_range(31)), 1'($urandom_range(1)), 1'($urandom_range(1))};
            send_residue(w, 1'b0, '0);
         end else begin
            send_sequence(($urandom_range(99) < 45) ? OP_REFERENCE : OP_QUERY,
                          $urandom_range(9) != 0, n);
            sent += n;
         end
      end
      // close the phase on a query end so its result drains the pipeline
      send_sequence(OP_QUERY, 1'b1, n);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_counts.size() == 0) begin
            report_mismatch("unexpected word, reference_kmers", rsp_chan.reference_kmers, 0);
         end else begin
            expected_now = pending_counts.pop_front();
            if (rsp_chan.reference_kmers !== expected_now.reference_kmers)
               report_mismatch("reference_kmers", rsp_chan.reference_kmers,
                               expected_now.reference_kmers);
            if (rsp_chan.query_kmers !== expected_now.query_kmers)
               report_mismatch("query_kmers", rsp_chan.query_kmers, expected_now.query_kmers);
            if (rsp_chan.query_hits !== expected_now.query_hits)
               report_mismatch("query_hits", rsp_chan.query_hits, expected_now.query_hits);
         end
      end
   end

   // receiver stall pattern, re-chosen each time its step counter runs out
   initial begin
      rsp_chan.ready = 1'b0;
      stall_step     = 0;
      stall_map      = '1;
      stall_pos      = '0;
      forever begin
         @(negedge clock);
         if (stall_step == 0) begin
            stall_step = $urandom_range(64, 300);
            case ($urandom_range(2))
               0: stall_map = '1;
               1: stall_map = $urandom();
               default: stall_map = ($urandom() & $urandom()) | 32'h1;
            endcase
         end
         stall_step--;
         rsp_chan.ready <= stall_map[stall_pos];
         stall_pos++;
      end
   end

   initial begin
      #40ms;
      $display("** kmer_containment_filter_core: FAILED **");
      $finish;
   end

   initial begin
      reset                  = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.opcode        = OP_CLEAR;
      req_chan.residue       = '0;
      req_chan.residue_valid = 1'b0;
      req_chan.last          = 1'b0;
      csr_write_enable       = 1'b0;
      csr_write_data         = KLEN_RESET;
      kmer_length_shadow     = KLEN_RESET;
      window_index           = 0;
      run_length             = 0;
      reference_total        = '0;
      query_total            = '0;
      hit_total              = '0;
      mismatch_count         = 0;
      burst_left             = 0;
      clears_left            = 3;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         send_residue({DIRECTED_ROWS[i].opcode, DIRECTED_ROWS[i].residue,
                       DIRECTED_ROWS[i].residue_valid, DIRECTED_ROWS[i].last},
                      DIRECTED_ROWS[i].typed,
                      {DIRECTED_ROWS[i].ref_k, DIRECTED_ROWS[i].qry_k, DIRECTED_ROWS[i].hits});
      end

      foreach (PHASE_KLEN[p]) begin
         write_kmer_length(PHASE_KLEN[p]);
         run_phase(PHASE_ITEMS);
      end

      req_chan.valid <= 1'b0;
      while (pending_counts.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("** kmer_containment_filter_core: PASSED **");
      end else begin
         $display("** kmer_containment_filter_core: FAILED **");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+sv
sv/kcf_pkg.sv
sv/kcf_req_if.sv
sv/kcf_rsp_if.sv
sv/kcf_ram.sv
sv/kmer_containment_filter_core.sv
sv/kcf_checker.sv
dv/tb_kmer_containment_filter_core.sv
